[src/assert_macros.svh]
// Assertion helpers shared by the erosion RTL.
// Each expects signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/lero_pkg.sv]
// Shared types and constants of the 3x3 label erosion block.
// No dependencies; used by every module of the block except lero_ram.
`timescale 1ns / 1ps

package lero_pkg;

  localparam int PIX_W     = 8;
  localparam int TAP_W     = PIX_W + 1;
  localparam int CFG_DIM_W = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [TAP_W-1:0] FLUSH_MARK = 9'h100;
  localparam logic [PIX_W-1:0] LABEL_RST  = 8'd255;
  localparam int               WIDTH_RST  = 640;
  localparam int               HEIGHT_RST = 480;

  typedef logic [TAP_W-1:0] tap_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LABEL  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  // travels with each pixel down the cell chain
  typedef struct packed {
    logic emit;   // this item releases a result
    logic last;   // result is the frame's last pixel
    logic match;  // window rows so far all equal the label (and not border)
  } lero_tok_t;

endpackage

[src/lero_ram.sv]
// Generic single-clock RAM, one write and one registered read port.
// No dependencies; read returns the old word on a same-address write.
`timescale 1ns / 1ps

module lero_ram #(
  parameter int DATA_W = 9,
  parameter int DEPTH  = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/lero_cell.sv]
// One window row of the erosion chain: two taps plus the incoming pixel, row compare,
// optional line RAM. Depends on lero_pkg and lero_ram; the RAM's old word feeds the next cell up.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lero_cell import lero_pkg::*; #(
  parameter int  MAX_WIDTH = 1024,
  parameter bit  LINE      = 1'b1,
  localparam int CW        = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [PIX_W-1:0] label,
  input  logic             in_valid,
  output logic             in_ready,
  input  tap_t             in_pix,
  input  logic [CW-1:0]    in_col,
  input  lero_tok_t        in_tok,
  output logic             out_valid,
  input  logic             out_ready,
  output tap_t             out_pix,
  output logic [CW-1:0]    out_col,
  output lero_tok_t        out_tok
);

  tap_t taps [2];
  tap_t lbl;
  logic take;
  logic eq;

  assign lbl      = {1'b0, label};
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign eq       = (taps[0] == lbl) && (taps[1] == lbl) && (in_pix == lbl);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      taps[0]       <= taps[1];
      taps[1]       <= in_pix;
      out_col       <= in_col;
      out_tok.emit  <= in_tok.emit;
      out_tok.last  <= in_tok.last;
      out_tok.match <= in_tok.match && eq;
    end
  end

  generate
    if (LINE) begin : g_line
      lero_ram #(
        .DATA_W(TAP_W),
        .DEPTH (MAX_WIDTH)
      ) u_line (
        .clk  (clk),
        .we   (take),
        .waddr(in_col),
        .wdata(in_pix),
        .re   (take),
        .raddr(in_col),
        .rdata(out_pix)
      );
    end else begin : g_top_row
      assign out_pix = '0;
    end
  endgenerate

  // a stalled request must keep its line data and token
  `ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
               out_valid && $stable(out_pix) && $stable(out_tok),
               "stalled cell output changed")

endmodule

[src/lero_pos.sv]
// Configuration registers and frame position counters of the erosion block.
// Depends on lero_pkg; tags each accepted pixel with column, emit, last, border mask.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lero_pos import lero_pkg::*; #(
  parameter int  MAX_WIDTH  = 1024,
  parameter int  MAX_HEIGHT = 1024,
  localparam int CW         = $clog2(MAX_WIDTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DIM_W-1:0] cfg_data,
  input  logic                 take,
  output logic [PIX_W-1:0]     label,
  output logic [CW-1:0]        col,
  output lero_tok_t            tok
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
  localparam int H_RST = (HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST;

  logic [WW-1:0] w_reg;
  logic [HW-1:0] h_reg;
  logic [CW-1:0] in_col;
  logic [1:0]    in_rows;
  logic [CW-1:0] out_col;
  logic [RW-1:0] out_row;
  cfg_idx_t      idx;
  logic          restart;
  logic          col_end;
  logic          ocol_end;
  logic          orow_end;
  logic          emit;
  logic          last;

  function automatic logic [WW-1:0] clamp_w(input logic [CFG_DIM_W-1:0] v);
    if (v == '0) begin
      return WW'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      return WW'(MAX_WIDTH);
    end
    return WW'(v);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [CFG_DIM_W-1:0] v);
    if (v == '0) begin
      return HW'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      return HW'(MAX_HEIGHT);
    end
    return HW'(v);
  endfunction

  assign idx     = cfg_idx_t'(cfg_index);
  assign restart = cfg_valid && ((idx == CFG_WIDTH) || (idx == CFG_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      label <= LABEL_RST;
      w_reg <= WW'(W_RST);
      h_reg <= HW'(H_RST);
    end else if (cfg_valid) begin
      unique case (idx)
        CFG_LABEL:  label <= cfg_data[PIX_W-1:0];
        CFG_WIDTH:  w_reg <= clamp_w(cfg_data);
        CFG_HEIGHT: h_reg <= clamp_h(cfg_data);
        default: ;
      endcase
    end
  end

  assign col_end  = (WW'(in_col) == w_reg - WW'(1));
  assign ocol_end = (WW'(out_col) == w_reg - WW'(1));
  assign orow_end = (HW'(out_row) == h_reg - HW'(1));
  // first row and one pixel of a frame only fill the window
  assign emit     = !((in_rows == 2'd0) || ((in_rows == 2'd1) && (in_col == '0)));
  assign last     = orow_end && ocol_end;

  assign col       = in_col;
  assign tok.emit  = emit;
  assign tok.last  = last;
  assign tok.match = (out_row != '0) && !orow_end && (out_col != '0) && !ocol_end;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col  <= '0;
      in_rows <= 2'd0;
      out_col <= '0;
      out_row <= '0;
    end else if (take) begin
      if (emit && last) begin
        in_col  <= '0;
        in_rows <= 2'd0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (col_end) begin
          in_col <= '0;
          if (in_rows != 2'd2) begin
            in_rows <= in_rows + 2'd1;
          end
        end else begin
          in_col <= in_col + CW'(1);
        end
        if (emit) begin
          if (ocol_end) begin
            out_col <= '0;
            out_row <= out_row + RW'(1);
          end else begin
            out_col <= out_col + CW'(1);
          end
        end
      end
    end
  end

  `ASSERT_ALWAYS(a_in_col_range, WW'(in_col) < w_reg, "input column beyond frame width")
  `ASSERT_ALWAYS(a_out_row_range, HW'(out_row) < h_reg, "output row beyond frame height")

endmodule

[src/label_erosion_3x3_unit.sv]
// Top level of the 3x3 label erosion block: position tracker, three window cells, output register.
// Depends on lero_pkg, lero_pos, lero_cell (and lero_ram through the cells).
//
// Usage:
//   Pixels of a frame enter in raster order on s_axis, one request per pixel;
//   tuser marks a flush item, sent frame_width+1 times after the last pixel.
//   Each pixel leaves as label_value when its whole 3x3 window equals the
//   label, otherwise as label_value-1; border pixels always take label-1.
//   Results on m_axis lag the input by frame_width+1 requests; m_axis_tlast
//   flags the frame's last pixel, after which a new frame starts.
//   An accepted request then passes two more window cells and reaches the
//   output register in the output stage.
//   Throughput: one pixel per clock while m_axis is not stalled, set by one read
//   and one write per clock on each of the two line RAMs.
//   cfg writes (index 0 label, 1 width, 2 height) are taken at once and
//   belong to idle periods; width and height writes restart the frame.
//   Reset restores label 255 and a 640 x 480 frame; line RAMs are not
//   cleared, their stale words only reach border pixels.
//   A stalled receiver holds the result; upstream requests keep flowing
//   until the four pipeline slots are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module label_erosion_3x3_unit import lero_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] pixel_in
  input  logic                 s_axis_tuser,   // [0] flush
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [7:0] pixel_out
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DIM_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [PIX_W-1:0] label;
  logic [CW-1:0]    pos_col;
  lero_tok_t        pos_tok;
  tap_t             in_pix;
  logic             take;
  logic             out_free;

  logic             cv   [3];
  logic             crdy [3];
  tap_t             cpix [3];
  logic [CW-1:0]    ccol [3];
  lero_tok_t        ctok [3];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = crdy[0];
  assign take          = s_axis_tvalid && crdy[0];
  assign in_pix        = s_axis_tuser ? FLUSH_MARK : {1'b0, s_axis_tdata};
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  lero_pos #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_pos (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .take     (take),
    .label    (label),
    .col      (pos_col),
    .tok      (pos_tok)
  );

  // cell 0: bottom window row, cell 1: middle, cell 2: top
  generate
    for (genvar i = 0; i < 3; i++) begin : g_cell
      if (i == 0) begin : g_first
        lero_cell #(
          .MAX_WIDTH(MAX_WIDTH),
          .LINE     (1'b1)
        ) u_cell (
          .clk      (clk),
          .rst      (rst),
          .label    (label),
          .in_valid (s_axis_tvalid),
          .in_ready (crdy[i]),
          .in_pix   (in_pix),
          .in_col   (pos_col),
          .in_tok   (pos_tok),
          .out_valid(cv[i]),
          .out_ready(crdy[i+1]),
          .out_pix  (cpix[i]),
          .out_col  (ccol[i]),
          .out_tok  (ctok[i])
        );
      end else if (i == 1) begin : g_mid
        lero_cell #(
          .MAX_WIDTH(MAX_WIDTH),
          .LINE     (1'b1)
        ) u_cell (
          .clk      (clk),
          .rst      (rst),
          .label    (label),
          .in_valid (cv[i-1]),
          .in_ready (crdy[i]),
          .in_pix   (cpix[i-1]),
          .in_col   (ccol[i-1]),
          .in_tok   (ctok[i-1]),
          .out_valid(cv[i]),
          .out_ready(crdy[i+1]),
          .out_pix  (cpix[i]),
          .out_col  (ccol[i]),
          .out_tok  (ctok[i])
        );
      end else begin : g_last
        lero_cell #(
          .MAX_WIDTH(MAX_WIDTH),
          .LINE     (1'b0)
        ) u_cell (
          .clk      (clk),
          .rst      (rst),
          .label    (label),
          .in_valid (cv[i-1]),
          .in_ready (crdy[i]),
          .in_pix   (cpix[i-1]),
          .in_col   (ccol[i-1]),
          .in_tok   (ctok[i-1]),
          .out_valid(cv[i]),
          .out_ready(out_free),
          .out_pix  (cpix[i]),
          .out_col  (ccol[i]),
          .out_tok  (ctok[i])
        );
      end
    end
  endgenerate

  // non-emitting requests are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cv[2] && out_free) begin
      m_axis_tvalid <= ctok[2].emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cv[2] && out_free) begin
      m_axis_tdata <= ctok[2].match ? label : label - 8'd1;
      m_axis_tlast <= ctok[2].last;
    end
  end

  `ASSERT_IMPLIES(a_ready_when_out_empty, !m_axis_tvalid, s_axis_tready,
                  "input stalled with an empty output register")

endmodule
